// ===== src/pdsrv_pkg.sv =====
// Shared types and constants for the encoder PD position servo.
// Used by the channel interfaces, the servo top level and its checker.
// No dependencies.
package pdsrv_pkg;

	// Request codes carried in req_type.
	typedef enum logic [1:0] {
		REQ_ENC   = 2'd0,
		REQ_TICK  = 2'd1,
		REQ_START = 2'd2,
		REQ_ZERO  = 2'd3
	} req_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_GAIN_P     = 3'd0,
		CFG_GAIN_D     = 3'd1,
		CFG_FULL_POWER = 3'd2,
		CFG_SEQ_POS_0  = 3'd3,
		CFG_SEQ_POS_1  = 3'd4,
		CFG_SEQ_POS_2  = 3'd5,
		CFG_SEQ_POS_3  = 3'd6
	} cfg_idx_t;

	localparam int CFG_DATA_W = 16;
	localparam int ELAPSED_W  = 20;
	localparam int POS_W      = 16;
	localparam int DUTY_W     = 8;

	// Reset values of the configuration registers.
	localparam logic [15:0] GAIN_P_RST     = 16'd8960;
	localparam logic [15:0] GAIN_D_RST     = 16'd384;
	localparam logic [7:0]  FULL_POWER_RST = 8'd255;

	// Number of sequence targets that are stepped through.
	localparam logic [2:0] SEQ_LEN = 3'd4;

	// Derivative scale: microseconds per second.
	localparam logic [19:0] D_SCALE = 20'd1000000;

	// Settle thresholds in ticks.
	localparam logic [5:0] SETTLE_HOLD = 6'd5;
	localparam logic [5:0] SETTLE_DONE = 6'd30;
	localparam logic [5:0] SETTLE_MAX  = 6'd63;
	localparam logic signed [15:0] SETTLE_BAND = 16'sd2;

endpackage

// ===== src/pdsrv_req_if.sv =====
// Request channel of the servo: valid/ready handshake and request payload.
// Depends on pdsrv_pkg for the field widths.
interface pdsrv_req_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      req_type;
	logic                            enc_a;
	logic                            enc_b;
	logic [pdsrv_pkg::ELAPSED_W-1:0] elapsed_us;

	modport source (output valid, req_type, enc_a, enc_b, elapsed_us, input ready);
	modport sink (input valid, req_type, enc_a, enc_b, elapsed_us, output ready);
endinterface

// ===== src/pdsrv_rsp_if.sv =====
// Result channel of the servo: valid/ready handshake and drive result payload.
// Depends on pdsrv_pkg for the field widths.
interface pdsrv_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [pdsrv_pkg::DUTY_W-1:0]       pwm_duty;
	logic                               drive_reverse;
	logic                               reached_done;
	logic signed [pdsrv_pkg::POS_W-1:0] cur_position;
	logic                               sequence_busy;

	modport source (output valid, pwm_duty, drive_reverse, reached_done, cur_position,
		sequence_busy, input ready);
	modport sink (input valid, pwm_duty, drive_reverse, reached_done, cur_position,
		sequence_busy, output ready);
endinterface

// ===== src/encoder_pd_position_servo_top.sv =====
// Encoder PD position servo. Encoder, start and zero requests complete in the cycle
// that accepts them. A control tick steps through MUL_P, MUL_D, MUL_K, DIV, SUM and
// OUT before the next request is accepted: one shared 32x20 multiplier runs three
// products, then a restoring divider retires two quotient bits per cycle, then a sum
// and an output stage. The result waits in an output register until taken.
// arst_n clears control, servo and output-valid state and loads the config defaults.
module encoder_pd_position_servo_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [2:0]        cfg_index,
	input  logic [pdsrv_pkg::CFG_DATA_W-1:0] cfg_data,
	pdsrv_req_if.sink         req,
	pdsrv_rsp_if.source       rsp
);

	localparam int NUM_W = 52;
	localparam int SUM_W = 54;
	localparam logic [4:0] DIV_LAST = 5'(NUM_W / 2 - 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MUL_P = 7'b0000010,
		ST_MUL_D = 7'b0000100,
		ST_MUL_K = 7'b0001000,
		ST_DIV   = 7'b0010000,
		ST_SUM   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [15:0]        gain_p_q;
	logic [15:0]        gain_d_q;
	logic [7:0]         full_power_q;
	logic signed [15:0] seq_pos_q [4];

	// Servo state.
	logic [15:0]        enc_count_q;
	logic               last_a_q;
	logic signed [15:0] prior_err_q;
	logic signed [15:0] goal_q;
	logic [5:0]         settle_q;
	logic [2:0]         seq_idx_q;
	logic               seq_run_q;

	// Tick working registers.
	logic signed [15:0] err_q;
	logic [19:0]        el_q;
	logic [15:0]        de_mag_q;
	logic               de_neg_q;
	logic signed [32:0] p_q;
	logic [NUM_W-1:0]   num_q;
	logic [19:0]        rem_q;
	logic [4:0]         cnt_q;
	logic signed [SUM_W-1:0] sum_q;

	// Output register.
	logic               out_valid_q;
	logic [7:0]         pwm_q;
	logic               rev_q;
	logic               done_q;
	logic [15:0]        pos_out_q;
	logic               busy_q;

	logic               in_fire;
	logic               out_load;

	// Shared multiplier.
	logic [31:0]        mul_a;
	logic [19:0]        mul_b;
	logic [NUM_W-1:0]   mul_y;

	// Error of the incoming tick.
	logic signed [16:0] diff17;
	logic signed [15:0] err_sat;
	logic [15:0]        err_mag;
	logic signed [16:0] de17;

	// Divider steps.
	logic [20:0]        rem_a;
	logic [20:0]        rem_a_sub;
	logic [20:0]        rem_b;
	logic [20:0]        rem_b_sub;
	logic               q_hi;
	logic               q_lo;
	logic [19:0]        rem_mid;
	logic [19:0]        rem_next;

	// Final stage.
	logic signed [SUM_W-1:0] d_ext;
	logic [SUM_W-1:0]   s_mag;
	logic [7:0]         pwm_raw;
	logic [5:0]         settle_next;
	logic               settle_hold;
	logic [2:0]         idx_next;
	logic               run_next;
	logic signed [15:0] goal_next;
	logic [7:0]         pwm_final;

	assign req.ready = (state_q == ST_IDLE);
	assign in_fire   = req.valid && req.ready;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || rsp.ready);

	assign rsp.valid         = out_valid_q;
	assign rsp.pwm_duty      = pwm_q;
	assign rsp.drive_reverse = rev_q;
	assign rsp.reached_done  = done_q;
	assign rsp.cur_position  = pos_out_q;
	assign rsp.sequence_busy = busy_q;

	// Saturated position error and its magnitude.
	always_comb begin
		diff17 = {enc_count_q[15], enc_count_q} - {goal_q[15], goal_q};
		if (diff17[16] != diff17[15]) begin
			err_sat = diff17[16] ? 16'sh8000 : 16'sh7FFF;
		end else begin
			err_sat = diff17[15:0];
		end
		err_mag = err_q[15] ? (~err_q + 16'd1) : err_q;
		de17 = {err_q[15], err_q} - {prior_err_q[15], prior_err_q};
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (state_q)
			ST_MUL_P: begin
				mul_a = {16'd0, gain_p_q};
				mul_b = {4'd0, err_mag};
			end
			ST_MUL_D: begin
				mul_a = {16'd0, gain_d_q};
				mul_b = {4'd0, de_mag_q};
			end
			default: begin
				mul_a = num_q[31:0];
				mul_b = pdsrv_pkg::D_SCALE;
			end
		endcase
		mul_y = {20'd0, mul_a} * {32'd0, mul_b};
	end

	// Two restoring division steps per cycle.
	always_comb begin
		rem_a     = {rem_q, num_q[NUM_W-1]};
		rem_a_sub = rem_a - {1'b0, el_q};
		q_hi      = (rem_a >= {1'b0, el_q});
		rem_mid   = q_hi ? rem_a_sub[19:0] : rem_a[19:0];
		rem_b     = {rem_mid, num_q[NUM_W-2]};
		rem_b_sub = rem_b - {1'b0, el_q};
		q_lo      = (rem_b >= {1'b0, el_q});
		rem_next  = q_lo ? rem_b_sub[19:0] : rem_b[19:0];
	end

	// Drive value, settle counter and sequence step of a finished tick.
	always_comb begin
		d_ext   = de_neg_q ? -$signed({2'b00, num_q}) : $signed({2'b00, num_q});
		s_mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		pwm_raw = (s_mag[SUM_W-1:8] > {{(SUM_W-16){1'b0}}, full_power_q})
			? full_power_q : s_mag[15:8];

		if (err_q < pdsrv_pkg::SETTLE_BAND && err_q > -pdsrv_pkg::SETTLE_BAND) begin
			settle_next = (settle_q == pdsrv_pkg::SETTLE_MAX) ? settle_q : settle_q + 6'd1;
		end else begin
			settle_next = 6'd0;
		end
		settle_hold = (settle_next > pdsrv_pkg::SETTLE_HOLD);

		idx_next  = seq_idx_q;
		run_next  = seq_run_q;
		goal_next = goal_q;
		pwm_final = pwm_raw;
		if (settle_hold) begin
			pwm_final = 8'd0;
			if (seq_run_q) begin
				goal_next = seq_pos_q[seq_idx_q[1:0]];
				idx_next  = seq_idx_q + 3'd1;
				if (idx_next >= pdsrv_pkg::SEQ_LEN) begin
					run_next = 1'b0;
				end
			end
		end
		if (run_next && idx_next == 3'd1) begin
			pwm_final = full_power_q;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q     <= pdsrv_pkg::GAIN_P_RST;
			gain_d_q     <= pdsrv_pkg::GAIN_D_RST;
			full_power_q <= pdsrv_pkg::FULL_POWER_RST;
			for (int i = 0; i < 4; i++) begin
				seq_pos_q[i] <= 16'sd0;
			end
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				pdsrv_pkg::CFG_GAIN_P:     gain_p_q     <= cfg_data;
				pdsrv_pkg::CFG_GAIN_D:     gain_d_q     <= cfg_data;
				pdsrv_pkg::CFG_FULL_POWER: full_power_q <= cfg_data[7:0];
				pdsrv_pkg::CFG_SEQ_POS_0:  seq_pos_q[0] <= cfg_data;
				pdsrv_pkg::CFG_SEQ_POS_1:  seq_pos_q[1] <= cfg_data;
				pdsrv_pkg::CFG_SEQ_POS_2:  seq_pos_q[2] <= cfg_data;
				pdsrv_pkg::CFG_SEQ_POS_3:  seq_pos_q[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer and servo state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			enc_count_q <= 16'd0;
			last_a_q    <= 1'b0;
			prior_err_q <= 16'sd0;
			goal_q      <= 16'sd0;
			settle_q    <= 6'd0;
			seq_idx_q   <= 3'd0;
			seq_run_q   <= 1'b0;
			cnt_q       <= 5'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						unique case (req.req_type)
							pdsrv_pkg::REQ_ENC: begin
								if (req.enc_a != last_a_q) begin
									last_a_q    <= req.enc_a;
									enc_count_q <= (req.enc_a == req.enc_b)
										? enc_count_q + 16'd1 : enc_count_q - 16'd1;
								end
							end
							pdsrv_pkg::REQ_START: begin
								seq_idx_q <= 3'd0;
								seq_run_q <= 1'b1;
								goal_q    <= seq_pos_q[0];
							end
							pdsrv_pkg::REQ_ZERO: begin
								enc_count_q <= 16'd0;
							end
							default: begin
								state_q <= ST_MUL_P;
							end
						endcase
					end
				end
				ST_MUL_P: state_q <= ST_MUL_D;
				ST_MUL_D: state_q <= ST_MUL_K;
				ST_MUL_K: begin
					cnt_q   <= 5'd0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_SUM;
					end
				end
				ST_SUM: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						prior_err_q <= err_q;
						settle_q    <= settle_next;
						seq_idx_q   <= idx_next;
						seq_run_q   <= run_next;
						goal_q      <= goal_next;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Arithmetic datapath of a tick.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				err_q <= err_sat;
				el_q  <= (req.elapsed_us == 20'd0) ? 20'd1 : req.elapsed_us;
			end
			ST_MUL_P: begin
				p_q      <= $signed({1'b0, mul_y[31:0]});
				de_mag_q <= de17[16] ? 16'(-de17) : de17[15:0];
				de_neg_q <= de17[16];
			end
			ST_MUL_D: begin
				num_q <= mul_y;
				if (err_q[15]) begin
					p_q <= -p_q;
				end
			end
			ST_MUL_K: begin
				num_q <= mul_y;
				rem_q <= 20'd0;
			end
			ST_DIV: begin
				num_q <= {num_q[NUM_W-3:0], q_hi, q_lo};
				rem_q <= rem_next;
			end
			ST_SUM: begin
				sum_q <= SUM_W'(p_q) + d_ext;
			end
			ST_OUT: begin
				if (out_load) begin
					pwm_q     <= pwm_final;
					rev_q     <= !sum_q[SUM_W-1] && (sum_q != '0);
					done_q    <= (settle_next > pdsrv_pkg::SETTLE_DONE);
					pos_out_q <= enc_count_q;
					busy_q    <= run_next;
				end
			end
			default: begin
			end
		endcase
	end

	// Output valid: set when a result is loaded, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== src/pdsrv_checker.sv =====
// Port-level checks for the encoder PD position servo, bound to its top level.
// Depends on pdsrv_pkg for the request codes.
module pdsrv_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] in_req_type,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] pwm_duty,
	input logic       reached_done,
	input logic       sequence_busy
);

	// A result that is not taken stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result transaction dropped before it was taken");

	// An accepted control tick keeps the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_req_type == pdsrv_pkg::REQ_TICK |=> !in_ready)
		else $error("block ready right after a control tick transaction");

	// Other requests leave the block ready again in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_req_type != pdsrv_pkg::REQ_TICK |=> in_ready)
		else $error("block busy after a single-cycle request transaction");

	// Once settled and with no sequence running, the drive is off.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reached_done && !sequence_busy |-> pwm_duty == 8'd0)
		else $error("drive active in a settled result transaction");

endmodule

bind encoder_pd_position_servo_top pdsrv_checker u_pdsrv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (req.valid),
	.in_ready      (req.ready),
	.in_req_type   (req.req_type),
	.out_valid     (rsp.valid),
	.out_ready     (rsp.ready),
	.pwm_duty      (rsp.pwm_duty),
	.reached_done  (rsp.reached_done),
	.sequence_busy (rsp.sequence_busy)
);

// ===== sim/encoder_pd_position_servo_top_tb.sv =====
// Self-checking testbench for encoder_pd_position_servo_top: a directed table, then steered
// random traffic with idling on both channels, checked against a predictor of the servo.
// Depends on pdsrv_pkg, pdsrv_req_if, pdsrv_rsp_if and the servo RTL.
`timescale 1ns / 1ps

module encoder_pd_position_servo_top_tb;

	// Register index that maps to no register; writes to it must be ignored.
	localparam logic [2:0] CFG_UNUSED = 3'd7;
	// Cycles allowed after the last result before a register write or the end of the run.
	localparam int DRAIN_GUARD = 40;
	localparam int PHASE_COUNT = 6;
	localparam int PHASE_ITEMS = 215;
	localparam int WIND_STEPS  = 24;

	typedef logic [pdsrv_pkg::ELAPSED_W-1:0] elapsed_t;

	typedef struct packed {
		pdsrv_pkg::req_t kind;
		logic            enc_a;
		logic            enc_b;
		elapsed_t        elapsed_us;
	} servo_req_t;

	typedef struct packed {
		logic [pdsrv_pkg::DUTY_W-1:0]       pwm_duty;
		logic                               drive_reverse;
		logic                               reached_done;
		logic signed [pdsrv_pkg::POS_W-1:0] cur_position;
		logic                               sequence_busy;
	} drive_result_t;

	typedef struct packed {
		pdsrv_pkg::req_t kind;
		logic            enc_a;
		logic            enc_b;
		elapsed_t        elapsed_us;
		logic            typed;
		drive_result_t   result;
	} stim_row_t;

	localparam drive_result_t NO_RESULT = '0;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_wr_en = 1'b0;
	logic [2:0]                       cfg_index = '0;
	logic [pdsrv_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	pdsrv_req_if req_ch ();
	pdsrv_rsp_if rsp_ch ();

	encoder_pd_position_servo_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Predictor copy of the configuration registers.
	logic [15:0]        kp_q88 = pdsrv_pkg::GAIN_P_RST;
	logic [15:0]        kd_q88 = pdsrv_pkg::GAIN_D_RST;
	logic [7:0]         duty_limit = pdsrv_pkg::FULL_POWER_RST;
	logic signed [15:0] target_pos [4] = '{default: '0};

	// Predictor copy of the servo state.
	logic [15:0] pos_count = '0;
	logic        a_level = 1'b0;
	longint      err_prev = 0;
	int          goal_pos = 0;
	logic [5:0]  settle_cnt = '0;
	logic [2:0]  step_idx = '0;
	logic        seq_active = 1'b0;

	drive_result_t pending_drive [$];
	int            mismatch_count = 0;
	int            send_idle_pct = 0;
	int            recv_idle_pct = 0;

	// Directed table: encoder edge cases, zero and extreme elapsed times, and a sequence
	// that is restarted while it runs and then walks to its end.
	stim_row_t directed_rows [0:24] = '{
		'{pdsrv_pkg::REQ_TICK, 1'b0, 1'b0, 20'd0, 1'b1,
			'{8'd0, 1'b0, 1'b0, 16'sd0, 1'b0}},
		'{pdsrv_pkg::REQ_ENC,   1'b1, 1'b1, 20'd0,       1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_ENC,   1'b1, 1'b0, 20'd0,       1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_ENC,   1'b0, 1'b1, 20'd0,       1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_ENC,   1'b0, 1'b0, 20'd0,       1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_ENC,   1'b1, 1'b0, 20'd0,       1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_TICK,  1'b0, 1'b0, 20'hFFFFF,   1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_ZERO,  1'b1, 1'b1, 20'hFFFFF,   1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_TICK, 1'b1, 1'b1, 20'd1, 1'b1,
			'{8'd255, 1'b1, 1'b0, 16'sd0, 1'b0}},
		'{pdsrv_pkg::REQ_START, 1'b0, 1'b0, 20'd0,       1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_TICK,  1'b0, 1'b0, 20'd1000,    1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_TICK,  1'b0, 1'b0, 20'd1000,    1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_TICK,  1'b0, 1'b0, 20'd1000,    1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_TICK,  1'b0, 1'b0, 20'd1000,    1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_START, 1'b1, 1'b0, 20'd5,       1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_TICK,  1'b0, 1'b0, 20'd1000,    1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_TICK,  1'b0, 1'b0, 20'd1000,    1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_TICK,  1'b0, 1'b0, 20'd1000,    1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_TICK,  1'b0, 1'b0, 20'd1000,    1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_ENC,   1'b0, 1'b0, 20'd0,       1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_TICK,  1'b1, 1'b1, 20'd777,     1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_ZERO,  1'b0, 1'b0, 20'd0,       1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_TICK,  1'b0, 1'b1, 20'h80000,   1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_ENC,   1'b1, 1'b1, 20'd0,       1'b0, NO_RESULT},
		'{pdsrv_pkg::REQ_TICK,  1'b1, 1'b0, 20'h7FFFF,   1'b0, NO_RESULT}
	};

	// Clock generation.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Advance the servo prediction by one accepted request.
	function automatic void predict_request(input servo_req_t item, output bit produced,
		output drive_result_t res);
		longint err, delta, prop, deriv, total, mag, duty, span;
		produced = 1'b0;
		res = '0;
		case (item.kind)
			pdsrv_pkg::REQ_ENC: begin
				// Count only on a change of channel A; direction follows A against B.
				if (item.enc_a != a_level) begin
					a_level = item.enc_a;
					if (item.enc_a == item.enc_b)
						pos_count = pos_count + 16'd1;
					else
						pos_count = pos_count - 16'd1;
				end
			end
			pdsrv_pkg::REQ_START: begin
				step_idx = '0;
				seq_active = 1'b1;
				goal_pos = target_pos[0];
			end
			pdsrv_pkg::REQ_ZERO: pos_count = '0;
			default: begin
				span = (item.elapsed_us == '0) ? 64'sd1 : longint'(item.elapsed_us);
				err = longint'($signed(pos_count)) - longint'(goal_pos);
				if (err > 32767)
					err = 32767;
				if (err < -32768)
					err = -32768;
				// Q8.8 drive signal: proportional term plus rate-scaled derivative term.
				delta = err - err_prev;
				prop = longint'(kp_q88) * err;
				mag = longint'(kd_q88) * (delta < 0 ? -delta : delta)
					* longint'(pdsrv_pkg::D_SCALE) / span;
				deriv = (delta < 0) ? -mag : mag;
				total = prop + deriv;
				duty = (total < 0 ? -total : total) >> 8;
				if (duty > longint'(duty_limit))
					duty = longint'(duty_limit);
				res.drive_reverse = (total > 0);
				err_prev = err;
				// Settle counting inside the dead band, then the sequence step.
				if (err < longint'(pdsrv_pkg::SETTLE_BAND)
					&& err > -longint'(pdsrv_pkg::SETTLE_BAND)) begin
					if (settle_cnt < pdsrv_pkg::SETTLE_MAX)
						settle_cnt = settle_cnt + 6'd1;
				end else begin
					settle_cnt = '0;
				end
				if (settle_cnt > pdsrv_pkg::SETTLE_HOLD) begin
					duty = 0;
					if (seq_active) begin
						goal_pos = target_pos[step_idx[1:0]];
						step_idx = step_idx + 3'd1;
						if (step_idx >= pdsrv_pkg::SEQ_LEN)
							seq_active = 1'b0;
					end
				end
				if (seq_active && step_idx == 3'd1)
					duty = longint'(duty_limit);
				res.pwm_duty = 8'(duty);
				res.reached_done = (settle_cnt > pdsrv_pkg::SETTLE_DONE);
				res.cur_position = pos_count;
				res.sequence_busy = seq_active;
				produced = 1'b1;
			end
		endcase
	endfunction

	function automatic elapsed_t pick_elapsed();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return elapsed_t'($urandom);
			default: return elapsed_t'($urandom_range(200, 5000));
		endcase
	endfunction

	// Mostly steer the encoder toward the active goal and tick, so that the servo settles
	// and the sequence advances; the rest is noise and sequence starts.
	function automatic servo_req_t pick_request();
		servo_req_t item;
		int         roll;
		int         gap;
		logic       next_a;
		roll = $urandom_range(0, 199);
		gap = int'($signed(pos_count)) - goal_pos;
		next_a = ~a_level;
		item.kind = pdsrv_pkg::REQ_TICK;
		item.enc_a = 1'($urandom);
		item.enc_b = 1'($urandom);
		item.elapsed_us = pick_elapsed();
		if (roll < 10) begin
			case ($urandom_range(0, 2))
				0: item.kind = pdsrv_pkg::REQ_ENC;
				1: item.kind = pdsrv_pkg::REQ_ZERO;
				default: item.kind = pdsrv_pkg::REQ_TICK;
			endcase
		end else if ((roll < 12 && !seq_active) || roll == 12) begin
			item.kind = pdsrv_pkg::REQ_START;
		end else if (gap != 0 && $urandom_range(0, 99) < 65) begin
			// Step toward the goal, and now and then away from it.
			item.kind = pdsrv_pkg::REQ_ENC;
			item.enc_a = next_a;
			item.enc_b = ((gap < 0) ^ ($urandom_range(0, 9) == 0)) ? next_a : ~next_a;
		end
		return item;
	endfunction

	// Drive one request transaction; returns at the clock edge that accepted it.
	task automatic send_request(input servo_req_t item, input bit typed,
		input drive_result_t typed_res);
		bit            produced;
		drive_result_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= item.kind;
		req_ch.enc_a <= item.enc_a;
		req_ch.enc_b <= item.enc_b;
		req_ch.elapsed_us <= item.elapsed_us;
		do
			@(negedge clk);
		while (!req_ch.ready);
		@(posedge clk);
		predict_request(item, produced, predicted);
		if (produced)
			pending_drive.push_back(typed ? typed_res : predicted);
	endtask

	// Hold the request channel idle until every tick has produced its result.
	task automatic wait_drained(input int guard_cycles);
		req_ch.valid <= 1'b0;
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (guard_cycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx,
		input logic [pdsrv_pkg::CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			pdsrv_pkg::CFG_GAIN_P: kp_q88 = data;
			pdsrv_pkg::CFG_GAIN_D: kd_q88 = data;
			pdsrv_pkg::CFG_FULL_POWER: duty_limit = data[7:0];
			pdsrv_pkg::CFG_SEQ_POS_0, pdsrv_pkg::CFG_SEQ_POS_1,
			pdsrv_pkg::CFG_SEQ_POS_2, pdsrv_pkg::CFG_SEQ_POS_3:
				target_pos[int'(idx) - int'(pdsrv_pkg::CFG_SEQ_POS_0)] = data;
			default: ;
		endcase
	endtask

	function automatic logic [15:0] small_target();
		return 16'(int'($urandom_range(0, 40)) - 20);
	endfunction

	// Register settings per phase: moderate, all zero, all at the top, and random ones.
	task automatic configure_phase(input int phase);
		logic [15:0] kp, kd;
		logic [7:0]  fp;
		logic [15:0] goals [4];
		foreach (goals[i])
			goals[i] = small_target();
		case (phase)
			0: begin
				kp = 16'(256 * $urandom_range(1, 40));
				kd = 16'($urandom_range(0, 1024));
				fp = 8'($urandom_range(100, 255));
			end
			1: begin
				kp = '0;
				kd = '0;
				fp = '0;
			end
			2: begin
				kp = '1;
				kd = '1;
				fp = '1;
				goals = '{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF};
			end
			4: begin
				kp = 16'($urandom_range(0, 1023));
				kd = 16'($urandom_range(0, 255));
				fp = 8'($urandom);
			end
			default: begin
				kp = 16'($urandom);
				kd = 16'($urandom);
				fp = 8'($urandom);
			end
		endcase
		write_reg(pdsrv_pkg::CFG_GAIN_P, kp);
		write_reg(pdsrv_pkg::CFG_GAIN_D, kd);
		write_reg(pdsrv_pkg::CFG_FULL_POWER, {8'($urandom), fp});
		write_reg(pdsrv_pkg::CFG_SEQ_POS_0, goals[0]);
		write_reg(pdsrv_pkg::CFG_SEQ_POS_1, goals[1]);
		write_reg(pdsrv_pkg::CFG_SEQ_POS_2, goals[2]);
		write_reg(pdsrv_pkg::CFG_SEQ_POS_3, goals[3]);
		if (phase == 1 || phase == 5)
			write_reg(CFG_UNUSED, 16'($urandom));
		cfg_wr_en <= 1'b0;
	endtask

	// Count straight up for a run of steps, with a tick now and then to observe
	// the position.
	task automatic wind_position(input int steps);
		servo_req_t step;
		servo_req_t tick;
		tick = '{pdsrv_pkg::REQ_TICK, 1'b0, 1'b0, 20'd1000};
		for (int i = 1; i <= steps; i++) begin
			step = '{pdsrv_pkg::REQ_ENC, ~a_level, ~a_level, elapsed_t'($urandom)};
			send_request(step, 1'b0, NO_RESULT);
			if (i % 8 == 0 || i == steps)
				send_request(tick, 1'b0, NO_RESULT);
		end
	endtask

	task automatic set_idling(input int phase);
		case (phase / 2)
			0: begin
				send_idle_pct = 19;
				recv_idle_pct = 57;
			end
			1: begin
				send_idle_pct = 57;
				recv_idle_pct = 19;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	// Result channel: random back-pressure.
	always @(posedge clk) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	task automatic compare_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// Check each result transaction against the oldest prediction.
	always @(negedge clk) begin : collect_result
		drive_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_drive.size() == 0) begin
				$error("result with no tick outstanding: pwm_duty %0d cur_position %0d",
					rsp_ch.pwm_duty, rsp_ch.cur_position);
				mismatch_count++;
			end else begin
				want = pending_drive.pop_front();
				compare_field("pwm_duty", want.pwm_duty, rsp_ch.pwm_duty);
				compare_field("drive_reverse", want.drive_reverse, rsp_ch.drive_reverse);
				compare_field("reached_done", want.reached_done, rsp_ch.reached_done);
				compare_field("cur_position", $signed(want.cur_position),
					$signed(rsp_ch.cur_position));
				compare_field("sequence_busy", want.sequence_busy, rsp_ch.sequence_busy);
			end
		end
	end

	// Stimulus sequence.
	initial begin
		req_ch.valid = 1'b0;
		req_ch.req_type = pdsrv_pkg::REQ_ENC;
		req_ch.enc_a = 1'b0;
		req_ch.enc_b = 1'b0;
		req_ch.elapsed_us = '0;
		rsp_ch.ready = 1'b0;
		set_idling(0);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request('{directed_rows[i].kind, directed_rows[i].enc_a, directed_rows[i].enc_b,
				directed_rows[i].elapsed_us}, directed_rows[i].typed, directed_rows[i].result);

		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			wait_drained(DRAIN_GUARD);
			set_idling(phase);
			configure_phase(phase);
			if (phase == 2)
				wind_position(WIND_STEPS);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Once, let the sender stall until the servo has caught up.
				if (phase == 3 && n == PHASE_ITEMS / 2)
					wait_drained(0);
				send_request(pick_request(), 1'b0, NO_RESULT);
			end
		end

		wait_drained(DRAIN_GUARD);
		if (mismatch_count == 0)
			$display("encoder_pd_position_servo_top_tb: done, clean");
		else
			$display("encoder_pd_position_servo_top_tb: done, errors");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#40ms;
		$display("encoder_pd_position_servo_top_tb: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
src/pdsrv_pkg.sv
src/pdsrv_req_if.sv
src/pdsrv_rsp_if.sv
src/encoder_pd_position_servo_top.sv
src/pdsrv_checker.sv
sim/encoder_pd_position_servo_top_tb.sv
